### design/afa_pkg.sv
`timescale 1ns / 1ps

package afa_pkg;

    // table and address geometry
    localparam int AREA_COUNT = 8;
    localparam int AREA_W     = (AREA_COUNT > 1) ? $clog2(AREA_COUNT) : 1;
    localparam int PAGE_SHIFT = 12;

    // field widths fixed by the interface
    localparam int ADDR_W     = 64;
    localparam int FRAME_W    = 52;
    localparam int OP_W       = 2;
    localparam int INDEX_W    = 3;
    localparam int CFG_IDX_W  = 2;

    // last frame of an area and the running next-free frame
    localparam int LF_W       = ADDR_W - PAGE_SHIFT;
    localparam int NF_W       = ((LF_W > FRAME_W) ? LF_W : FRAME_W) + 1;

    // bound on the number of steps one allocate may take
    localparam int STEP_LIMIT = 2 * AREA_COUNT + 8;
    localparam int STEP_W     = $clog2(STEP_LIMIT + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_LAST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOOTINFO_FIRST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOOTINFO_LAST  = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic write_entry;
        logic clear_nf;
        logic scan_start;
        logic scan_cmp;
        logic scan_end;
        logic rd_chosen;
        logic skip_kernel;
        logic skip_boot;
        logic grant;
        logic finish;
    } afa_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic have_area;
        logic scan_last;
        logic past_area;
        logic in_kernel;
        logic in_boot;
    } afa_sts_t;

endpackage

### design/afa_ctrl.sv
`timescale 1ns / 1ps

module afa_ctrl
    import afa_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] operation,
    input  afa_sts_t        sts,
    output afa_cmd_t        cmd,
    output logic            busy
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WRITE  = 3'd1;
    localparam logic [2:0] ST_CH_RD  = 3'd2;
    localparam logic [2:0] ST_CH_CMP = 3'd3;
    localparam logic [2:0] ST_CH_END = 3'd4;
    localparam logic [2:0] ST_AL_RD  = 3'd5;
    localparam logic [2:0] ST_AL_CHK = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic              in_alloc_reg, in_alloc_next;

    // state, step count and caller flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            steps_reg    <= '0;
            in_alloc_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            steps_reg    <= steps_next;
            in_alloc_reg <= in_alloc_next;
        end
    end

    // sequencing of one transaction
    always_comb
    begin
        state_next    = state_reg;
        steps_next    = steps_reg;
        in_alloc_next = in_alloc_reg;
        cmd           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    unique case (operation)
                        OP_WRITE:
                        begin
                            state_next = ST_WRITE;
                        end
                        OP_INIT:
                        begin
                            cmd.clear_nf   = 1'b1;
                            cmd.scan_start = 1'b1;
                            in_alloc_next  = 1'b0;
                            state_next     = ST_CH_RD;
                        end
                        OP_ALLOC:
                        begin
                            steps_next    = '0;
                            in_alloc_next = 1'b1;
                            state_next    = ST_AL_RD;
                        end
                        default:
                        begin
                            cmd.finish = 1'b1;
                        end
                    endcase
                end
            end

            ST_WRITE:
            begin
                cmd.write_entry = 1'b1;
                cmd.finish      = 1'b1;
                state_next      = ST_IDLE;
            end

            // each table entry takes a read state, then a compare state
            ST_CH_RD:
            begin
                state_next = ST_CH_CMP;
            end

            ST_CH_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                state_next   = sts.scan_last ? ST_CH_END : ST_CH_RD;
            end

            ST_CH_END:
            begin
                cmd.scan_end = 1'b1;
                if (in_alloc_reg)
                begin
                    state_next = ST_AL_RD;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // loop head of an allocate
            ST_AL_RD:
            begin
                cmd.rd_chosen = 1'b1;
                if (!sts.have_area || (steps_reg == STEP_W'(STEP_LIMIT)))
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_AL_CHK;
                end
            end

            ST_AL_CHK:
            begin
                cmd.rd_chosen = 1'b1;
                if (sts.past_area)
                begin
                    steps_next     = steps_reg + STEP_W'(1);
                    cmd.scan_start = 1'b1;
                    state_next     = ST_CH_RD;
                end
                else if (sts.in_kernel)
                begin
                    steps_next      = steps_reg + STEP_W'(1);
                    cmd.skip_kernel = 1'b1;
                    state_next      = ST_AL_RD;
                end
                else if (sts.in_boot)
                begin
                    steps_next    = steps_reg + STEP_W'(1);
                    cmd.skip_boot = 1'b1;
                    state_next    = ST_AL_RD;
                end
                else
                begin
                    cmd.grant  = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### design/afa_datapath.sv
`timescale 1ns / 1ps

module afa_datapath
    import afa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  afa_cmd_t             cmd,
    output afa_sts_t             sts,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAME_W-1:0]   cfg_data,
    input  logic [INDEX_W-1:0]   area_index,
    input  logic [ADDR_W-1:0]    area_base,
    input  logic [ADDR_W-1:0]    area_length,
    input  logic                 area_usable,
    output logic                 done,
    output logic                 granted,
    output logic [FRAME_W-1:0]   frame_number
);

    // area table, no reset: an unwritten entry is read in a scan but never qualifies
    logic [ADDR_W-1:0] base_mem [AREA_COUNT];
    logic [LF_W-1:0]   last_mem [AREA_COUNT];

    logic [AREA_COUNT-1:0] qualify_reg;

    logic [FRAME_W-1:0] kernel_first_reg, kernel_last_reg;
    logic [FRAME_W-1:0] boot_first_reg, boot_last_reg;

    logic [NF_W-1:0]    next_free_reg;
    logic [AREA_W-1:0]  chosen_reg;
    logic               have_area_reg;
    logic [AREA_W-1:0]  scan_idx_reg;
    logic               found_reg;
    logic [AREA_W-1:0]  best_idx_reg;
    logic [ADDR_W-1:0]  best_base_reg;

    logic [INDEX_W-1:0] item_index_reg;
    logic [ADDR_W-1:0]  item_base_reg;
    logic [ADDR_W-1:0]  item_length_reg;
    logic               item_usable_reg;

    logic [ADDR_W-1:0]  rd_base_reg;
    logic [LF_W-1:0]    rd_last_reg;

    logic               done_reg, granted_reg;
    logic [FRAME_W-1:0] frame_number_reg;

    logic [AREA_W-1:0]  rd_addr;
    logic [AREA_W-1:0]  wr_addr;
    logic               wr_in_range;
    logic [ADDR_W-1:0]  end_addr;
    logic [NF_W-1:0]    rd_last_ext;
    logic [NF_W-1:0]    best_start;
    logic               candidate;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_first_reg <= '0;
            kernel_last_reg  <= '0;
            boot_first_reg   <= '0;
            boot_last_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KERNEL_FIRST:   kernel_first_reg <= cfg_data;
                REG_KERNEL_LAST:    kernel_last_reg  <= cfg_data;
                REG_BOOTINFO_FIRST: boot_first_reg   <= cfg_data;
                REG_BOOTINFO_LAST:  boot_last_reg    <= cfg_data;
                default:            kernel_first_reg <= kernel_first_reg;
            endcase
        end
    end

    // transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_index_reg  <= area_index;
            item_base_reg   <= area_base;
            item_length_reg <= area_length;
            item_usable_reg <= area_usable;
        end
    end

    // last frame of the entry being written, kept with the entry
    assign end_addr    = item_base_reg + item_length_reg - ADDR_W'(1);
    assign wr_addr     = AREA_W'(item_index_reg);
    assign wr_in_range = (32'(item_index_reg) < 32'(AREA_COUNT));

    // table write and registered read
    assign rd_addr = cmd.rd_chosen ? chosen_reg : scan_idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && wr_in_range)
        begin
            base_mem[wr_addr] <= item_base_reg;
            last_mem[wr_addr] <= end_addr[ADDR_W-1:PAGE_SHIFT];
        end
        rd_base_reg <= base_mem[rd_addr];
        rd_last_reg <= last_mem[rd_addr];
    end

    // an entry qualifies when it is usable and not empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qualify_reg <= '0;
        end
        else if (cmd.write_entry && wr_in_range)
        begin
            qualify_reg[wr_addr] <= item_usable_reg && (item_length_reg != '0);
        end
    end

    // area selection compare
    assign rd_last_ext = NF_W'(rd_last_reg);
    assign best_start  = NF_W'(best_base_reg[ADDR_W-1:PAGE_SHIFT]);
    assign candidate   = qualify_reg[scan_idx_reg]
                         && (rd_last_ext >= next_free_reg)
                         && (!found_reg || (rd_base_reg < best_base_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
        end
        else if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_cmp)
        begin
            scan_idx_reg <= scan_idx_reg + AREA_W'(1);
            if (candidate)
            begin
                found_reg    <= 1'b1;
                best_idx_reg <= scan_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_cmp && candidate)
        begin
            best_base_reg <= rd_base_reg;
        end
    end

    // allocator state: next free frame and chosen area
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg <= '0;
            chosen_reg    <= '0;
            have_area_reg <= 1'b0;
        end
        else if (cmd.clear_nf)
        begin
            next_free_reg <= '0;
        end
        else if (cmd.scan_end)
        begin
            have_area_reg <= found_reg;
            if (found_reg)
            begin
                chosen_reg <= best_idx_reg;
                if (next_free_reg < best_start)
                begin
                    next_free_reg <= best_start;
                end
            end
        end
        else if (cmd.skip_kernel)
        begin
            next_free_reg <= NF_W'(kernel_last_reg) + NF_W'(1);
        end
        else if (cmd.skip_boot)
        begin
            next_free_reg <= NF_W'(boot_last_reg) + NF_W'(1);
        end
        else if (cmd.grant)
        begin
            next_free_reg <= next_free_reg + NF_W'(1);
        end
    end

    // status towards the controller
    always_comb
    begin
        sts.have_area = have_area_reg;
        sts.scan_last = (scan_idx_reg == AREA_W'(AREA_COUNT - 1));
        sts.past_area = (next_free_reg > rd_last_ext);
        sts.in_kernel = (next_free_reg >= NF_W'(kernel_first_reg))
                        && (next_free_reg <= NF_W'(kernel_last_reg));
        sts.in_boot   = (next_free_reg >= NF_W'(boot_first_reg))
                        && (next_free_reg <= NF_W'(boot_last_reg));
    end

    // result registers, one strobe per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg         <= 1'b0;
            granted_reg      <= 1'b0;
            frame_number_reg <= '0;
        end
        else
        begin
            done_reg         <= cmd.finish;
            granted_reg      <= cmd.grant;
            frame_number_reg <= cmd.grant ? next_free_reg[FRAME_W-1:0] : '0;
        end
    end

    assign done         = done_reg;
    assign granted      = granted_reg;
    assign frame_number = frame_number_reg;

endmodule

### design/area_frame_allocator_core.sv
`timescale 1ns / 1ps

// Bump allocator for physical page frames over a table of eight memory areas.
// A transaction is taken when start is high and busy low; its result is shown
// for exactly one cycle with done high and cannot be held off. Write items
// pass through the write state before they finish, and an unknown operation
// finishes straight from idle. Init reads and then compares each table entry
// in turn and finishes after the last one. An allocate reads and checks the
// chosen area; each kernel or boot-info range skipped and each move to a new
// area, which rescans the table, sends it round again before it grants. All
// table reads use the single registered read port of the area table.
// Configuration writes take effect at once and belong to idle periods.

module area_frame_allocator_core
    import afa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      operation,
    input  logic [INDEX_W-1:0]   area_index,
    input  logic [ADDR_W-1:0]    area_base,
    input  logic [ADDR_W-1:0]    area_length,
    input  logic                 area_usable,
    output logic                 done,
    output logic                 granted,
    output logic [FRAME_W-1:0]   frame_number,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAME_W-1:0]   cfg_data
);

    afa_cmd_t cmd;
    afa_sts_t sts;

    // sequencing
    afa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    // area table, frame arithmetic and result registers
    afa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .area_index   (area_index),
        .area_base    (area_base),
        .area_length  (area_length),
        .area_usable  (area_usable),
        .done         (done),
        .granted      (granted),
        .frame_number (frame_number)
    );

endmodule

### design/afa_checker.sv
`timescale 1ns / 1ps

module afa_checker
    import afa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic                 granted,
    input logic [FRAME_W-1:0]   frame_number
);

    // a result only appears once the block has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // every return to idle delivers a result
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("block went idle without a result");

    // an accepted transaction either starts work or answers at once
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction was dropped");

    // a grant comes only with the result strobe, a refusal carries frame zero
    a_grant_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        granted |-> done)
        else $error("grant outside a result");

    a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !granted) |-> (frame_number == '0))
        else $error("refused result carries a frame number");

endmodule

bind area_frame_allocator_core afa_checker u_afa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .granted      (granted),
    .frame_number (frame_number)
);
